// ===== hw/rtl/sfd_pkg.sv =====
// Shared constants, types and CRC function for the sensor frame deframer.
package sfd_pkg;

   localparam int MAX_PAYLOAD = 36;
   localparam int POS_W       = 6;

   localparam logic [7:0] SYNC_FIRST    = 8'h48;
   localparam logic [7:0] SYNC_SECOND   = 8'h53;
   localparam logic [7:0] PROTO_VERSION = 8'h01;
   localparam logic [7:0] GOOD_TYPE     = 8'h01;
   localparam logic [POS_W-1:0] GOOD_LENGTH = 6'd36;

   localparam logic [15:0] CRC_POLY = 16'h1021;

   // payload held as little-endian 32-bit words
   localparam int NUM_WORDS  = (MAX_PAYLOAD + 3) / 4;
   localparam int OUT_WORDS  = 9;
   localparam int ADDR_W     = $clog2(NUM_WORDS);
   localparam int CNT_W      = $clog2(OUT_WORDS + 1);
   localparam int OUT_IDX_W  = $clog2(OUT_WORDS);
   localparam int CMP_W      = (ADDR_W > CNT_W) ? ADDR_W : CNT_W;

   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      logic [31:0]       data;
   } wr_type;

   typedef struct packed {
      logic valid;
      logic ok;
   } done_type;

   typedef struct packed {
      logic             pend;
      logic [CNT_W-1:0] rd_idx;
   } store_stat_type;

   // CRC-16-CCITT, MSB first, one byte
   function automatic logic [15:0] crc_update(logic [15:0] crc, logic [7:0] b);
      logic [15:0] r;
      r = crc ^ {b, 8'h00};
      for (int i = 0; i < 8; i++) begin
         r = r[15] ? ((r << 1) ^ CRC_POLY) : (r << 1);
      end
      return r;
   endfunction

endpackage

// ===== hw/rtl/sensor_frame_deframer_crc16_unit.sv =====
// Throughput: one byte per cycle; header bytes and the CRC high byte never stall.
// The final CRC byte marks a frame pending; once rsp_valid is low, a rejected frame
// raises rsp_valid; a good frame unloads nine payload words from memory, one per cycle.
// The final CRC byte waits while the previous frame has not yet reached the result register;
// a payload word write waits while a frame is pending and that word is not yet read out.
// Synchronous active-high reset: parser hunts for sync, counters and flags clear.
module sensor_frame_deframer_crc16_unit (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [7:0]         req_rx_byte,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_frame_ok,
   output logic [31:0]        rsp_sequence_res,
   output logic [31:0]        rsp_gyro_x,
   output logic [31:0]        rsp_gyro_y,
   output logic [31:0]        rsp_gyro_z,
   output logic [31:0]        rsp_accel_x,
   output logic [31:0]        rsp_accel_y,
   output logic [31:0]        rsp_accel_z,
   output logic signed [31:0] rsp_pressure_pa,
   output logic signed [31:0] rsp_temp_centi_c,
   output logic signed [15:0] rsp_seq_gap,
   output logic [31:0]        rsp_reject_count
);
   import sfd_pkg::*;

   wr_type         wr;
   done_type       done;
   store_stat_type stat;

   sfd_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_rx_byte (req_rx_byte),
      .wr          (wr),
      .done        (done),
      .stat        (stat)
   );

   sfd_frame_store u_store (
      .clock            (clock),
      .reset            (reset),
      .wr               (wr),
      .done             (done),
      .stat             (stat),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_frame_ok     (rsp_frame_ok),
      .rsp_sequence_res (rsp_sequence_res),
      .rsp_gyro_x       (rsp_gyro_x),
      .rsp_gyro_y       (rsp_gyro_y),
      .rsp_gyro_z       (rsp_gyro_z),
      .rsp_accel_x      (rsp_accel_x),
      .rsp_accel_y      (rsp_accel_y),
      .rsp_accel_z      (rsp_accel_z),
      .rsp_pressure_pa  (rsp_pressure_pa),
      .rsp_temp_centi_c (rsp_temp_centi_c),
      .rsp_seq_gap      (rsp_seq_gap),
      .rsp_reject_count (rsp_reject_count)
   );

endmodule

// ===== hw/rtl/sfd_parser.sv =====
// Framing state machine, running CRC and payload word assembly.
module sfd_parser (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [7:0]             req_rx_byte,
   output sfd_pkg::wr_type        wr,
   output sfd_pkg::done_type      done,
   input  sfd_pkg::store_stat_type stat
);
   import sfd_pkg::*;

   typedef enum logic [7:0] {
      PH_SYNC1   = 8'b0000_0001,
      PH_SYNC2   = 8'b0000_0010,
      PH_VERSION = 8'b0000_0100,
      PH_TYPE    = 8'b0000_1000,
      PH_LENGTH  = 8'b0001_0000,
      PH_PAYLOAD = 8'b0010_0000,
      PH_CRC_HI  = 8'b0100_0000,
      PH_CRC_LO  = 8'b1000_0000
   } phase_type;

   phase_type        phase_ff, phase_in;
   logic [7:0]       type_ff, type_in;
   logic [POS_W-1:0] length_ff, length_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [15:0]      crc_ff, crc_in;
   logic [7:0]       crc_hi_ff, crc_hi_in;
   logic [31:0]      word_ff, word_in;

   logic             accept;
   logic [POS_W-1:0] pos_inc;
   logic [ADDR_W-1:0] widx;
   logic             word_done;
   logic             stall_wr;
   logic             stall_done;
   logic [31:0]      word_next;

   assign pos_inc   = pos_ff + 1'b1;
   assign widx      = ADDR_W'(pos_ff >> 2);
   assign word_done = (phase_ff == PH_PAYLOAD) && (pos_ff[1:0] == 2'b11);
   assign word_next = {req_rx_byte, word_ff[31:8]};

   // a word write must not overtake the unload of a pending frame
   assign stall_wr   = word_done && stat.pend &&
                       (CMP_W'(widx) >= CMP_W'(stat.rd_idx));
   assign stall_done = (phase_ff == PH_CRC_LO) && stat.pend;
   assign req_ready  = !(stall_wr || stall_done);
   assign accept     = req_valid && req_ready;

   always_comb begin
      phase_in  = phase_ff;
      type_in   = type_ff;
      length_in = length_ff;
      pos_in    = pos_ff;
      crc_in    = crc_ff;
      crc_hi_in = crc_hi_ff;
      word_in   = word_ff;
      wr        = '0;
      done      = '0;
      if (accept) begin
         unique case (phase_ff)
            PH_SYNC1: begin
               if (req_rx_byte == SYNC_FIRST) phase_in = PH_SYNC2;
            end
            PH_SYNC2: begin
               if (req_rx_byte == SYNC_SECOND) begin
                  phase_in = PH_VERSION;
               end else begin
                  phase_in = PH_SYNC1;
                  pos_in   = '0;
                  crc_in   = '0;
               end
            end
            PH_VERSION: begin
               if (req_rx_byte != PROTO_VERSION) begin
                  phase_in = PH_SYNC1;
                  pos_in   = '0;
                  crc_in   = '0;
               end else begin
                  crc_in   = crc_update(16'h0000, req_rx_byte);
                  phase_in = PH_TYPE;
               end
            end
            PH_TYPE: begin
               type_in  = req_rx_byte;
               crc_in   = crc_update(crc_ff, req_rx_byte);
               phase_in = PH_LENGTH;
            end
            PH_LENGTH: begin
               pos_in = '0;
               if (req_rx_byte == 8'h00 || req_rx_byte > 8'(MAX_PAYLOAD)) begin
                  phase_in = PH_SYNC1;
                  crc_in   = '0;
               end else begin
                  crc_in    = crc_update(crc_ff, req_rx_byte);
                  length_in = req_rx_byte[POS_W-1:0];
                  phase_in  = PH_PAYLOAD;
               end
            end
            PH_PAYLOAD: begin
               word_in = word_next;
               wr.en   = (pos_ff[1:0] == 2'b11);
               wr.addr = widx;
               wr.data = word_next;
               pos_in  = pos_inc;
               crc_in  = crc_update(crc_ff, req_rx_byte);
               if (pos_inc >= length_ff) phase_in = PH_CRC_HI;
            end
            PH_CRC_HI: begin
               crc_hi_in = req_rx_byte;
               phase_in  = PH_CRC_LO;
            end
            PH_CRC_LO: begin
               done.valid = 1'b1;
               done.ok    = ({crc_hi_ff, req_rx_byte} == crc_ff) &&
                            (type_ff == GOOD_TYPE) && (length_ff == GOOD_LENGTH);
               phase_in   = PH_SYNC1;
               pos_in     = '0;
               crc_in     = '0;
            end
            default: begin
               phase_in = PH_SYNC1;
               pos_in   = '0;
               crc_in   = '0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_SYNC1;
         type_ff   <= '0;
         length_ff <= '0;
         pos_ff    <= '0;
         crc_ff    <= '0;
         crc_hi_ff <= '0;
      end else begin
         phase_ff  <= phase_in;
         type_ff   <= type_in;
         length_ff <= length_in;
         pos_ff    <= pos_in;
         crc_ff    <= crc_in;
         crc_hi_ff <= crc_hi_in;
      end
      word_ff <= word_in;
   end

endmodule

// ===== hw/rtl/sfd_frame_store.sv =====
// Payload word memory, result unload sequencer and result register.
module sfd_frame_store (
   input  logic                    clock,
   input  logic                    reset,
   input  sfd_pkg::wr_type         wr,
   input  sfd_pkg::done_type       done,
   output sfd_pkg::store_stat_type stat,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic                    rsp_frame_ok,
   output logic [31:0]             rsp_sequence_res,
   output logic [31:0]             rsp_gyro_x,
   output logic [31:0]             rsp_gyro_y,
   output logic [31:0]             rsp_gyro_z,
   output logic [31:0]             rsp_accel_x,
   output logic [31:0]             rsp_accel_y,
   output logic [31:0]             rsp_accel_z,
   output logic signed [31:0]      rsp_pressure_pa,
   output logic signed [31:0]      rsp_temp_centi_c,
   output logic signed [15:0]      rsp_seq_gap,
   output logic [31:0]             rsp_reject_count
);
   import sfd_pkg::*;

   logic [31:0] mem [NUM_WORDS];
   logic [31:0] rd_data_ff;

   logic                 pend_ff, pend_in;
   logic                 ok_ff, ok_in;
   logic [CNT_W-1:0]     rd_idx_ff, rd_idx_in;
   logic                 rd_vld_ff, rd_vld_in;
   logic [OUT_IDX_W-1:0] rd_tag_ff, rd_tag_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [31:0]          out_word_ff [OUT_WORDS];
   logic [31:0]          out_word_in [OUT_WORDS];
   logic                 frame_ok_ff, frame_ok_in;
   logic [15:0]          gap_ff, gap_in;
   logic [31:0]          rej_out_ff, rej_out_in;
   logic [31:0]          last_seq_ff, last_seq_in;
   logic                 seen_ff, seen_in;
   logic [31:0]          rejected_ff, rejected_in;

   logic              issue;
   logic [ADDR_W-1:0] rd_addr;
   logic [31:0]       seq_diff;

   assign issue    = pend_ff && ok_ff && !rsp_valid_ff &&
                     (rd_idx_ff != CNT_W'(OUT_WORDS));
   assign rd_addr  = ADDR_W'(rd_idx_ff);
   assign seq_diff = rd_data_ff - last_seq_ff - 32'd1;

   always_ff @(posedge clock) begin
      if (wr.en) mem[wr.addr] <= wr.data;
      if (issue) rd_data_ff <= mem[rd_addr];
   end

   always_comb begin
      pend_in      = pend_ff;
      ok_in        = ok_ff;
      rd_idx_in    = rd_idx_ff;
      rd_vld_in    = issue;
      rd_tag_in    = OUT_IDX_W'(rd_idx_ff);
      rsp_valid_in = rsp_valid_ff;
      out_word_in  = out_word_ff;
      frame_ok_in  = frame_ok_ff;
      gap_in       = gap_ff;
      rej_out_in   = rej_out_ff;
      last_seq_in  = last_seq_ff;
      seen_in      = seen_ff;
      rejected_in  = rejected_ff;

      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;

      if (done.valid) begin
         pend_in   = 1'b1;
         ok_in     = done.ok;
         rd_idx_in = '0;
         if (!done.ok) rejected_in = rejected_ff + 32'd1;
      end

      if (issue) rd_idx_in = rd_idx_ff + 1'b1;

      // rejected frame: no payload read, all decoded fields zero
      if (pend_ff && !ok_ff && !rsp_valid_ff) begin
         for (int i = 0; i < OUT_WORDS; i++) out_word_in[i] = '0;
         frame_ok_in  = 1'b0;
         gap_in       = '0;
         rej_out_in   = rejected_ff;
         rsp_valid_in = 1'b1;
         pend_in      = 1'b0;
      end

      if (rd_vld_ff) begin
         out_word_in[rd_tag_ff] = rd_data_ff;
         if (rd_tag_ff == '0) begin
            gap_in      = seen_ff ? seq_diff[15:0] : 16'h0000;
            last_seq_in = rd_data_ff;
            seen_in     = 1'b1;
         end
         if (rd_tag_ff == OUT_IDX_W'(OUT_WORDS - 1)) begin
            frame_ok_in  = 1'b1;
            rej_out_in   = rejected_ff;
            rsp_valid_in = 1'b1;
            pend_in      = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff      <= 1'b0;
         ok_ff        <= 1'b0;
         rd_idx_ff    <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         last_seq_ff  <= '0;
         seen_ff      <= 1'b0;
         rejected_ff  <= '0;
      end else begin
         pend_ff      <= pend_in;
         ok_ff        <= ok_in;
         rd_idx_ff    <= rd_idx_in;
         rd_vld_ff    <= rd_vld_in;
         rsp_valid_ff <= rsp_valid_in;
         last_seq_ff  <= last_seq_in;
         seen_ff      <= seen_in;
         rejected_ff  <= rejected_in;
      end
      rd_tag_ff   <= rd_tag_in;
      out_word_ff <= out_word_in;
      frame_ok_ff <= frame_ok_in;
      gap_ff      <= gap_in;
      rej_out_ff  <= rej_out_in;
   end

   assign stat.pend   = pend_ff;
   assign stat.rd_idx = rd_idx_ff;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_frame_ok     = frame_ok_ff;
   assign rsp_sequence_res = out_word_ff[0];
   assign rsp_gyro_x       = out_word_ff[1];
   assign rsp_gyro_y       = out_word_ff[2];
   assign rsp_gyro_z       = out_word_ff[3];
   assign rsp_accel_x      = out_word_ff[4];
   assign rsp_accel_y      = out_word_ff[5];
   assign rsp_accel_z      = out_word_ff[6];
   assign rsp_pressure_pa  = signed'(out_word_ff[7]);
   assign rsp_temp_centi_c = signed'(out_word_ff[8]);
   assign rsp_seq_gap      = signed'(gap_ff);
   assign rsp_reject_count = rej_out_ff;

endmodule

// ===== hw/rtl/sfd_checker.sv =====
// Port-level checker for the deframer, bound to the top level.
module sfd_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic [7:0]         req_rx_byte,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic               rsp_frame_ok,
   input logic [31:0]        rsp_sequence_res,
   input logic [31:0]        rsp_gyro_x,
   input logic [31:0]        rsp_gyro_y,
   input logic [31:0]        rsp_gyro_z,
   input logic [31:0]        rsp_accel_x,
   input logic [31:0]        rsp_accel_y,
   input logic [31:0]        rsp_accel_z,
   input logic signed [31:0] rsp_pressure_pa,
   input logic signed [31:0] rsp_temp_centi_c,
   input logic signed [15:0] rsp_seq_gap,
   input logic [31:0]        rsp_reject_count
);
   logic [31:0] last_cnt_ff, last_cnt_in;
   logic        rsp_take;

   assign rsp_take    = rsp_valid && rsp_ready;
   assign last_cnt_in = rsp_take ? rsp_reject_count : last_cnt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         last_cnt_ff <= '0;
      end else begin
         last_cnt_ff <= last_cnt_in;
      end
   end

   // a waiting request keeps its byte
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req_rx_byte))
      else $error("request changed while waiting");

   // a stalled result holds its count and sequence
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_reject_count) &&
                                  $stable(rsp_sequence_res) && $stable(rsp_frame_ok))
      else $error("result changed while stalled");

   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_frame_ok |->
         rsp_sequence_res == 32'd0 && rsp_gyro_x == 32'd0 && rsp_gyro_y == 32'd0 &&
         rsp_gyro_z == 32'd0 && rsp_accel_x == 32'd0 && rsp_accel_y == 32'd0 &&
         rsp_accel_z == 32'd0 && rsp_pressure_pa == 32'sd0 &&
         rsp_temp_centi_c == 32'sd0 && rsp_seq_gap == 16'sd0)
      else $error("rejected frame carries nonzero fields");

   // reject count moves by one on each rejected frame only
   a_reject_count: assert property (@(posedge clock) disable iff (reset)
      rsp_take |-> (rsp_frame_ok ? (rsp_reject_count == last_cnt_ff) :
                                   (rsp_reject_count == last_cnt_ff + 32'd1)))
      else $error("reject count out of step");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind sensor_frame_deframer_crc16_unit sfd_checker u_sfd_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_ready        (req_ready),
   .req_rx_byte      (req_rx_byte),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_frame_ok     (rsp_frame_ok),
   .rsp_sequence_res (rsp_sequence_res),
   .rsp_gyro_x       (rsp_gyro_x),
   .rsp_gyro_y       (rsp_gyro_y),
   .rsp_gyro_z       (rsp_gyro_z),
   .rsp_accel_x      (rsp_accel_x),
   .rsp_accel_y      (rsp_accel_y),
   .rsp_accel_z      (rsp_accel_z),
   .rsp_pressure_pa  (rsp_pressure_pa),
   .rsp_temp_centi_c (rsp_temp_centi_c),
   .rsp_seq_gap      (rsp_seq_gap),
   .rsp_reject_count (rsp_reject_count)
);
